// ===== rtl/bga_pkg.sv =====
// ----------------------------------------------------------------------------
// bga_pkg: shared types and constants of the battery gauge
// Widths, discharge-curve breakpoints, register codes and the structs that
// travel between the pipeline modules.
// ----------------------------------------------------------------------------
package bga_pkg;

	// Readings per averaged group (default of the top-level parameter)
	localparam int unsigned AVG_COUNT_DEF = 8;

	// Field widths
	localparam int unsigned PIN_W   = 12;
	localparam int unsigned RATIO_W = 12;
	localparam int unsigned MV_W    = 15;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned VOLT_W  = 16;  // unsaturated cell voltage
	localparam int unsigned OFF_W   = 8;   // offset inside one curve segment
	localparam int unsigned FRAC_W  = 8;   // fraction bits of the divider ratio

	// Configuration register map
	localparam int unsigned APB_DW   = 32;
	localparam int unsigned APB_AW   = 4;
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_RATIO   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_MV  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_MV  = 2'd2;

	localparam logic [RATIO_W-1:0] RATIO_RST  = 12'd512;
	localparam logic [MV_W-1:0]    MIN_MV_RST = 15'd3000;
	localparam logic [MV_W-1:0]    MAX_MV_RST = 15'd4500;

	// Single-cell LiPo discharge curve, highest voltage first
	localparam int unsigned NUM_PTS = 11;
	localparam logic [VOLT_W-1:0] BP_MV [NUM_PTS] = '{
		16'd4200, 16'd4060, 16'd3980, 16'd3920, 16'd3870, 16'd3820,
		16'd3790, 16'd3770, 16'd3740, 16'd3680, 16'd3450
	};
	localparam logic [PCT_W-1:0] BP_PCT [NUM_PTS] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40, 7'd30, 7'd20, 7'd10, 7'd0
	};
	// Largest percent step between neighboring breakpoints
	localparam int unsigned MAX_STEP = 10;

	// Curve segment codes: full charge, interpolated segments 1..10, empty
	typedef logic [3:0] seg_t;
	localparam seg_t SEG_FULL  = 4'd0;
	localparam seg_t SEG_EMPTY = 4'd11;

	// Result queue
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic [MV_W-1:0]    min_mv;
		logic [MV_W-1:0]    max_mv;
	} cfg_t;

	typedef struct packed {
		logic [MV_W-1:0]  cell_mv;
		logic             present;
		seg_t             seg;
		logic [OFF_W-1:0] offset;
	} soc_s4_t;

	typedef struct packed {
		logic [MV_W-1:0]  cell_mv;
		logic             present;
		logic [PCT_W-1:0] percent;
	} result_t;

endpackage

// ===== rtl/bga_accum.sv =====
// ----------------------------------------------------------------------------
// bga_accum: group accumulator
// Sums pin readings; the reading that closes a group launches the full sum.
// ----------------------------------------------------------------------------
module bga_accum import bga_pkg::*; #(
	parameter int unsigned AVG_COUNT = AVG_COUNT_DEF,
	parameter int unsigned SUM_W     = PIN_W + $clog2(AVG_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [PIN_W-1:0] pin_mv,
	output logic             last,
	output logic [SUM_W-1:0] sum_s1,
	output logic             valid_s1
);

	localparam int unsigned CNT_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;

	assign last     = (cnt_q == CNT_W'(AVG_COUNT - 1));
	assign sum_next = sum_q + SUM_W'(pin_mv);

	// count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take && last;
			if (take) begin
				if (last) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_next;
				end
			end
		end
	end

	// finished group sum
	always_ff @(posedge clk) begin
		if (take && last) begin
			sum_s1 <= sum_next;
		end
	end

endmodule

// ===== rtl/bga_scale.sv =====
// ----------------------------------------------------------------------------
// bga_scale: group mean and divider scaling
// Stage 2 forms the truncated mean, stage 3 multiplies by the Q4.8 ratio.
// ----------------------------------------------------------------------------
module bga_scale import bga_pkg::*; #(
	parameter int unsigned AVG_COUNT = AVG_COUNT_DEF,
	parameter int unsigned SUM_W     = PIN_W + $clog2(AVG_COUNT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SUM_W-1:0]   sum_s1,
	input  logic               valid_s1,
	input  logic [RATIO_W-1:0] ratio,
	output logic [VOLT_W-1:0]  volt_s3,
	output logic               valid_s3
);

	localparam int unsigned L    = $clog2(AVG_COUNT);
	localparam int unsigned PR_W = PIN_W + RATIO_W;

	logic [PIN_W-1:0] mean_c;
	logic [PIN_W-1:0] mean_s2;
	logic             valid_s2;
	logic [PR_W-1:0]  prod_c;

	// mean: shift for a power-of-two group, else exact reciprocal multiply
	if ((1 << L) == AVG_COUNT) begin : g_shift
		assign mean_c = PIN_W'(sum_s1 >> L);
	end else begin : g_recip
		localparam int unsigned SHIFT = SUM_W + L;
		localparam int unsigned MW    = 2 * SUM_W + 1;
		localparam logic [SUM_W:0] RECIP =
			(SUM_W + 1)'(((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
		logic [MW-1:0] mprod;
		assign mprod  = MW'(sum_s1) * MW'(RECIP);
		assign mean_c = mprod[SHIFT +: PIN_W];
	end

	assign prod_c = PR_W'(mean_s2) * PR_W'(ratio);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		mean_s2 <= mean_c;
		volt_s3 <= prod_c[FRAC_W +: VOLT_W];
	end

endmodule

// ===== rtl/bga_soc.sv =====
// ----------------------------------------------------------------------------
// bga_soc: presence window and state of charge
// Stage 4 checks the window and finds the curve segment, stage 5
// interpolates inside the segment by threshold compares.
// ----------------------------------------------------------------------------
module bga_soc import bga_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VOLT_W-1:0] volt_s3,
	input  logic              valid_s3,
	input  cfg_t              cfg,
	output result_t           res_s5,
	output logic              valid_s5
);

	soc_s4_t          s4_c;
	soc_s4_t          s4_q;
	logic             valid_s4;
	result_t          res_c;
	logic [PCT_W-1:0] base_c;
	logic [PCT_W-1:0] step_c;
	logic [VOLT_W-1:0] den_c;
	logic [3:0]       inc_c;
	logic [VOLT_W-1:0] scaled_off;

	// window check, saturation and segment search (highest breakpoint wins)
	always_comb begin
		s4_c.present = (volt_s3 >= VOLT_W'(cfg.min_mv)) && (volt_s3 <= VOLT_W'(cfg.max_mv));
		s4_c.cell_mv = volt_s3[VOLT_W-1] ? {MV_W{1'b1}} : volt_s3[MV_W-1:0];
		s4_c.seg     = SEG_EMPTY;
		s4_c.offset  = '0;
		for (int i = NUM_PTS - 1; i >= 0; i--) begin
			if (volt_s3 >= BP_MV[i]) begin
				s4_c.seg    = seg_t'(i);
				s4_c.offset = OFF_W'(volt_s3 - BP_MV[i]);
			end
		end
	end

	// segment constants
	always_comb begin
		base_c = '0;
		step_c = '0;
		den_c  = '1;
		for (int i = 1; i < NUM_PTS; i++) begin
			if (s4_q.seg == seg_t'(i)) begin
				base_c = BP_PCT[i];
				step_c = BP_PCT[i-1] - BP_PCT[i];
				den_c  = BP_MV[i-1] - BP_MV[i];
			end
		end
	end

	// floor(offset * step / span) as a count of crossed thresholds
	always_comb begin
		scaled_off = VOLT_W'(s4_q.offset) * VOLT_W'(step_c);
		inc_c      = '0;
		for (int k = 1; k < MAX_STEP; k++) begin
			if (scaled_off >= VOLT_W'(k) * den_c) begin
				inc_c = inc_c + 1'b1;
			end
		end
	end

	// percent select
	always_comb begin
		res_c.cell_mv = s4_q.cell_mv;
		res_c.present = s4_q.present;
		priority if (!s4_q.present) begin
			res_c.percent = '0;
		end else if (s4_q.seg == SEG_FULL) begin
			res_c.percent = BP_PCT[0];
		end else if (s4_q.seg == SEG_EMPTY) begin
			res_c.percent = '0;
		end else begin
			res_c.percent = base_c + PCT_W'(inc_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		s4_q   <= s4_c;
		res_s5 <= res_c;
	end

endmodule

// ===== rtl/bga_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bga_out_fifo: result queue
// Holds finished results until the consumer takes them.
// ----------------------------------------------------------------------------
module bga_out_fifo import bga_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop_ready,
	output logic    pop_valid,
	output result_t pop_data
);

	result_t               mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/battery_gauge_from_adc.sv =====
// ----------------------------------------------------------------------------
// battery_gauge_from_adc: LiPo gauge fed by ADC pin readings
// Averages groups of readings, scales by the divider ratio, checks the
// presence window and maps the cell voltage to a state of charge.
//
//   channel  signals                              item
//   in       in_valid / in_ready, pin_mv          one pin reading (mV)
//   out      out_valid / out_ready, cell_mv,      one result per group
//            present, percent
//   config   psel penable pwrite paddr pwdata     register write / read
//            prdata pready
//
// One reading is taken every cycle while in_ready is high. A result is
// offered on the result channel once the group-closing reading has passed
// the mean, ratio multiply, segment search, interpolation and queue write
// steps, and it waits in the queue while out_ready is low. Reset restores
// the register defaults and clears the group. in_ready drops only for a
// group-closing reading while the 8-entry result queue is fully booked.
// ----------------------------------------------------------------------------
module battery_gauge_from_adc import bga_pkg::*; #(
	parameter int unsigned AVG_COUNT = AVG_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// reading channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIN_W-1:0]  pin_mv,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MV_W-1:0]   cell_mv,
	output logic              present,
	output logic [PCT_W-1:0]  percent,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int unsigned SUM_W = PIN_W + $clog2(AVG_COUNT);

	cfg_t                  cfg_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  take;
	logic                  last;
	logic [SUM_W-1:0]      sum_s1;
	logic                  valid_s1;
	logic [VOLT_W-1:0]     volt_s3;
	logic                  valid_s3;
	result_t               res_s5;
	logic                  valid_s5;
	result_t               out_res;
	logic [FIFO_CNT_W-1:0] booked_q;
	logic                  book;
	logic                  release_slot;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio  <= RATIO_RST;
			cfg_q.min_mv <= MIN_MV_RST;
			cfg_q.max_mv <= MAX_MV_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_RATIO:  cfg_q.ratio  <= pwdata[RATIO_W-1:0];
				REG_MIN_MV: cfg_q.min_mv <= pwdata[MV_W-1:0];
				REG_MAX_MV: cfg_q.max_mv <= pwdata[MV_W-1:0];
				default:    ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_RATIO:  prdata = APB_DW'(cfg_q.ratio);
			REG_MIN_MV: prdata = APB_DW'(cfg_q.min_mv);
			REG_MAX_MV: prdata = APB_DW'(cfg_q.max_mv);
			default:    prdata = '0;
		endcase
	end

	// queue slots booked by results in flight or waiting
	assign in_ready     = !last || (booked_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign take         = in_valid && in_ready;
	assign book         = take && last;
	assign release_slot = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			booked_q <= '0;
		end else if (book && !release_slot) begin
			booked_q <= booked_q + 1'b1;
		end else if (release_slot && !book) begin
			booked_q <= booked_q - 1'b1;
		end
	end

	bga_accum #(
		.AVG_COUNT (AVG_COUNT),
		.SUM_W     (SUM_W)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.pin_mv   (pin_mv),
		.last     (last),
		.sum_s1   (sum_s1),
		.valid_s1 (valid_s1)
	);

	bga_scale #(
		.AVG_COUNT (AVG_COUNT),
		.SUM_W     (SUM_W)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.sum_s1   (sum_s1),
		.valid_s1 (valid_s1),
		.ratio    (cfg_q.ratio),
		.volt_s3  (volt_s3),
		.valid_s3 (valid_s3)
	);

	bga_soc u_soc (
		.clk      (clk),
		.arst_n   (arst_n),
		.volt_s3  (volt_s3),
		.valid_s3 (valid_s3),
		.cfg      (cfg_q),
		.res_s5   (res_s5),
		.valid_s5 (valid_s5)
	);

	bga_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s5),
		.push_data (res_s5),
		.pop_ready (out_ready),
		.pop_valid (out_valid),
		.pop_data  (out_res)
	);

	assign cell_mv = out_res.cell_mv;
	assign present = out_res.present;
	assign percent = out_res.percent;

endmodule

// ===== test/battery_gauge_from_adc_tb.sv =====
// ----------------------------------------------------------------------------
// battery_gauge_from_adc_tb: self-checking bench for the battery gauge
// Sends ADC pin readings in groups of eight under a range of divider ratios
// and presence windows. A shadow model of the gauge predicts each group result
// and a monitor compares every accepted result against it field by field.
// Streamed tests idle both channels in random bursts, bar the closing stretch.
// ----------------------------------------------------------------------------
module battery_gauge_from_adc_tb;
	import bga_pkg::*;

	localparam int unsigned READS_PER_GROUP = AVG_COUNT_DEF;
	localparam int unsigned DRAIN_CYCLES    = 12;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam int unsigned CELL_MAX        = (1 << MV_W) - 1;
	// index with no register behind it
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIN_W-1:0]  pin_mv = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [MV_W-1:0]   cell_mv;
	logic              present;
	logic [PCT_W-1:0]  percent;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	battery_gauge_from_adc dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .pin_mv(pin_mv),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_mv(cell_mv), .present(present), .percent(percent),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// 10-unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow state of the gauge
	cfg_t        shadow_cfg;
	int unsigned grp_sum;
	int unsigned grp_cnt;
	result_t     gauge_q [$];

	// bookkeeping
	int unsigned mismatches = 0;
	int unsigned readings_sent = 0;
	int unsigned results_seen = 0;
	int unsigned settings_used = 0;
	bit          idle_allowed = 1'b1;
	bit          in_gaps = 1'b0;
	bit          out_stalls = 1'b0;
	int unsigned stall_left = 0;
	result_t     got_r;
	result_t     want_r;

	// state of charge from the unsaturated cell voltage
	function automatic int unsigned soc_from_mv(input int unsigned v);
		int unsigned i;
		if (v >= BP_MV[0]) return 100;
		for (i = 1; i < NUM_PTS; i++) begin
			if (v >= BP_MV[i])
				return BP_PCT[i] + ((v - BP_MV[i]) * (BP_PCT[i-1] - BP_PCT[i])) /
					(BP_MV[i-1] - BP_MV[i]);
		end
		return 0;
	endfunction

	// fold one accepted reading into the group, queue a result on the eighth
	task automatic gauge_predict(input logic [PIN_W-1:0] mv);
		int unsigned mean;
		int unsigned volt;
		result_t     r;
		grp_sum = grp_sum + mv;
		grp_cnt = grp_cnt + 1;
		if (grp_cnt == READS_PER_GROUP) begin
			mean = grp_sum / READS_PER_GROUP;
			grp_sum = 0;
			grp_cnt = 0;
			volt = (mean * shadow_cfg.ratio) >> FRAC_W;
			r.cell_mv = (volt > CELL_MAX) ? CELL_MAX[MV_W-1:0] : volt[MV_W-1:0];
			r.present = (volt >= shadow_cfg.min_mv) && (volt <= shadow_cfg.max_mv);
			r.percent = r.present ? PCT_W'(soc_from_mv(volt)) : '0;
			gauge_q.push_back(r);
		end
	endtask

	function automatic logic [APB_DW-1:0] shadow_reg(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_RATIO:  return APB_DW'(shadow_cfg.ratio);
			REG_MIN_MV: return APB_DW'(shadow_cfg.min_mv);
			REG_MAX_MV: return APB_DW'(shadow_cfg.max_mv);
			default:    return '0;
		endcase
	endfunction

	// tasks below start and end just after a falling edge

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_RATIO:  shadow_cfg.ratio  = data[RATIO_W-1:0];
			REG_MIN_MV: shadow_cfg.min_mv = data[MV_W-1:0];
			REG_MAX_MV: shadow_cfg.max_mv = data[MV_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
		logic [APB_DW-1:0] want;
		want = shadow_reg(idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("register %0d read: expected %0d, got %0d", idx, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_gauge_cfg(input int unsigned ratio, input int unsigned min_mv,
			input int unsigned max_mv);
		reg_write(REG_RATIO, ratio);
		reg_write(REG_MIN_MV, min_mv);
		reg_write(REG_MAX_MV, max_mv);
		settings_used++;
	endtask

	// one reading, with an optional idle burst ahead of it
	task automatic send_reading(input logic [PIN_W-1:0] mv);
		if (in_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		pin_mv   <= mv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gauge_predict(mv);
		readings_sent++;
		@(negedge clk);
	endtask

	// stop sending, wait for every queued result and the pipeline to settle
	task automatic drain_gauge();
		in_valid <= 1'b0;
		while (gauge_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// pin reading whose scaled mean mostly lands near an interesting cell voltage
	function automatic logic [PIN_W-1:0] aim_pin();
		int          sel;
		int          v;
		int unsigned m;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			v = $urandom_range(3400, 4260);
		else if (sel < 15)
			v = int'(BP_MV[$urandom_range(0, NUM_PTS - 1)]) + $urandom_range(0, 2) - 1;
		else if (sel < 18)
			v = ($urandom_range(0, 1) ? int'(shadow_cfg.min_mv) : int'(shadow_cfg.max_mv))
				+ $urandom_range(0, 4) - 2;
		else
			return PIN_W'($urandom_range(0, (1 << PIN_W) - 1));
		if (v < 0) v = 0;
		if (shadow_cfg.ratio == 0) return PIN_W'($urandom_range(0, (1 << PIN_W) - 1));
		m = (v * 256 + shadow_cfg.ratio - 1) / shadow_cfg.ratio;
		if (m > (1 << PIN_W) - 1) m = (1 << PIN_W) - 1;
		return m[PIN_W-1:0];
	endfunction

	// mostly steady groups aimed at the curve and window, some pure noise
	task automatic send_stream(input int n);
		int          k;
		int          mode;
		int          p;
		logic [PIN_W-1:0] base;
		for (k = 0; k < n; k++) begin
			if (k % READS_PER_GROUP == 0) begin
				mode       = $urandom_range(0, 9);
				base       = aim_pin();
				in_gaps    = idle_allowed && ($urandom_range(0, 3) != 0);
				out_stalls = idle_allowed && ($urandom_range(0, 3) != 0);
			end
			if (mode >= 8) begin
				p = $urandom_range(0, (1 << PIN_W) - 1);
			end else if (mode >= 4) begin
				p = int'(base) + $urandom_range(0, 6) - 3;
				if (p < 0) p = 0;
				if (p > (1 << PIN_W) - 1) p = (1 << PIN_W) - 1;
			end else begin
				p = int'(base);
			end
			send_reading(p[PIN_W-1:0]);
		end
		drain_gauge();
	endtask

	// register defaults, masking, read-back and the unmapped index
	task automatic test_register_access();
		reg_check(REG_RATIO);
		reg_check(REG_MIN_MV);
		reg_check(REG_MAX_MV);
		reg_write(REG_RATIO, 32'hFFFF_F0FF);
		reg_write(REG_MIN_MV, 32'hFFFF_8123);
		reg_write(REG_MAX_MV, 32'h1234_FFFF);
		reg_check(REG_RATIO);
		reg_check(REG_MIN_MV);
		reg_check(REG_MAX_MV);
		reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
		reg_check(REG_RATIO);
		reg_check(REG_MIN_MV);
		reg_check(REG_MAX_MV);
		set_gauge_cfg(RATIO_RST, MIN_MV_RST, MAX_MV_RST);
	endtask

	// full charge point, zero ratio with a window from zero, saturation
	task automatic test_directed_extremes();
		int k;
		in_gaps = 1'b0;
		out_stalls = 1'b0;
		for (k = 0; k < READS_PER_GROUP; k++) send_reading(12'd2100);
		drain_gauge();
		set_gauge_cfg(0, 0, MAX_MV_RST);
		for (k = 0; k < READS_PER_GROUP; k++)
			send_reading(k[0] ? '1 : '0);
		drain_gauge();
		// mean times ratio overflows cell_mv: clamped field, window sees the raw value
		set_gauge_cfg((1 << RATIO_W) - 1, 0, CELL_MAX);
		for (k = 0; k < READS_PER_GROUP; k++) send_reading('1);
		drain_gauge();
	endtask

	// interpolation over the discharge curve at unity and default ratio
	task automatic test_curve_sweep();
		set_gauge_cfg(256, MIN_MV_RST, MAX_MV_RST);
		send_stream(72);
		set_gauge_cfg(RATIO_RST, 3440, 4250);
		send_stream(72);
	endtask

	// divider ratio extremes; odd item counts let groups span settings
	task automatic test_divider_extremes();
		set_gauge_cfg(0, 0, 0);
		send_stream(41);
		set_gauge_cfg((1 << RATIO_W) - 1, 0, CELL_MAX);
		send_stream(39);
		set_gauge_cfg(2048, MIN_MV_RST, MAX_MV_RST);
		send_stream(40);
		set_gauge_cfg(1, 0, 20);
		send_stream(40);
	endtask

	// inverted, single-point and random presence windows
	task automatic test_window_edges();
		set_gauge_cfg(RATIO_RST, 4000, 3500);
		send_stream(48);
		set_gauge_cfg(256, 3900, 3900);
		send_stream(48);
		set_gauge_cfg($urandom_range(256, 2048), $urandom_range(0, 4000),
			$urandom_range(3500, CELL_MAX));
		send_stream(48);
	endtask

	// back-to-back items with both sides always ready
	task automatic test_steady_stream();
		idle_allowed = 1'b0;
		set_gauge_cfg(RATIO_RST, MIN_MV_RST, MAX_MV_RST);
		send_stream(80);
	endtask

	// result-side backpressure in random bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (out_stalls && $urandom_range(0, 4) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ready  <= 1'b1;
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_r.cell_mv = cell_mv;
			got_r.present = present;
			got_r.percent = percent;
			results_seen++;
			if (gauge_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: cell_mv %0d present %0d percent %0d",
						cell_mv, present, percent);
			end else begin
				want_r = gauge_q.pop_front();
				if (got_r.cell_mv !== want_r.cell_mv || got_r.present !== want_r.present ||
						got_r.percent !== want_r.percent) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d: expected mv %0d pres %0d pct %0d, got %0d %0d %0d",
							results_seen, want_r.cell_mv, want_r.present, want_r.percent,
							got_r.cell_mv, got_r.present, got_r.percent);
				end
			end
		end
	end

	// watchdog
	initial begin
		#3000000;
		$display("FAIL battery_gauge_from_adc");
		$finish;
	end

	initial begin
		shadow_cfg.ratio  = RATIO_RST;
		shadow_cfg.min_mv = MIN_MV_RST;
		shadow_cfg.max_mv = MAX_MV_RST;
		grp_sum = 0;
		grp_cnt = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_access();
		test_directed_extremes();
		test_curve_sweep();
		test_divider_extremes();
		test_window_edges();
		test_steady_stream();

		if (gauge_q.size() != 0) begin
			mismatches++;
			$display("%0d predicted results never arrived", gauge_q.size());
		end
		$display("Sent %0d readings under %0d register settings; %0d group results checked.",
			readings_sent, settings_used, results_seen);
		if (mismatches == 0)
			$display("PASS battery_gauge_from_adc");
		else
			$display("FAIL battery_gauge_from_adc");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bga_pkg.sv
rtl/bga_accum.sv
rtl/bga_scale.sv
rtl/bga_soc.sv
rtl/bga_out_fifo.sv
rtl/battery_gauge_from_adc.sv
test/battery_gauge_from_adc_tb.sv
